FILE: design/csrmv_pkg.sv
// ----------------------------------------------------------------------------
// csrmv_pkg
// Shared widths, opcodes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package csrmv_pkg;

  localparam int VEC_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 4;
  localparam int IDX_W         = 10;
  localparam int ROW_W         = 16;
  localparam int PART_W        = 32;
  localparam int ACC_W         = 64;
  localparam int ADDR_MAX_W    = 16;
  localparam int IDX_EXT_W     = ADDR_MAX_W + 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MAC   = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_MAC,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      in_range;
    logic [ADDR_MAX_W-1:0]     addr;
    logic signed [PART_W-1:0]  re;
    logic signed [PART_W-1:0]  im;
    logic                      end_of_row;
  } cmd_t;

endpackage

FILE: design/csrmv_in_if.sv
// ----------------------------------------------------------------------------
// csrmv_in_if
// Input channel: vector writes, matrix nonzeros and empty-row closes.
// ----------------------------------------------------------------------------
interface csrmv_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           op;
  logic [csrmv_pkg::IDX_W-1:0]          index;
  logic signed [csrmv_pkg::PART_W-1:0]  re;
  logic signed [csrmv_pkg::PART_W-1:0]  im;
  logic                                 end_of_row;

  modport source (output valid, op, index, re, im, end_of_row, input ready);
  modport sink   (input valid, op, index, re, im, end_of_row, output ready);
endinterface

FILE: design/csrmv_out_if.sv
// ----------------------------------------------------------------------------
// csrmv_out_if
// Output channel: one complex row sum per finished row.
// ----------------------------------------------------------------------------
interface csrmv_out_if;
  logic                                valid;
  logic                                ready;
  logic [csrmv_pkg::ROW_W-1:0]         row;
  logic signed [csrmv_pkg::ACC_W-1:0]  y_real;
  logic signed [csrmv_pkg::ACC_W-1:0]  y_imag;

  modport source (output valid, row, y_real, y_imag, input ready);
  modport sink   (input valid, row, y_real, y_imag, output ready);
endinterface

FILE: design/csrmv_front.sv
// ----------------------------------------------------------------------------
// csrmv_front
// Accepts input words, decodes the opcode and checks the index against the
// vector depth, then pushes a command word into the queue.
// ----------------------------------------------------------------------------
module csrmv_front #(
  parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF
) (
  csrmv_in_if.sink          cmd,
  input  logic              full,
  output logic              push,
  output csrmv_pkg::cmd_t   item
);

  localparam logic [csrmv_pkg::IDX_EXT_W-1:0] DEPTH_EXT = csrmv_pkg::IDX_EXT_W'(VEC_DEPTH);

  logic [csrmv_pkg::IDX_EXT_W-1:0] idx_ext;
  logic                            keep;

  assign cmd.ready = !full;

  always_comb begin
    idx_ext         = csrmv_pkg::IDX_EXT_W'(cmd.index);
    item.addr       = idx_ext[csrmv_pkg::ADDR_MAX_W-1:0];
    item.in_range   = idx_ext < DEPTH_EXT;
    item.re         = cmd.re;
    item.im         = cmd.im;
    item.end_of_row = cmd.end_of_row;
    keep            = 1'b1;
    unique case (cmd.op)
      csrmv_pkg::OP_WRITE: item.kind = csrmv_pkg::KIND_WRITE;
      csrmv_pkg::OP_MAC:   item.kind = csrmv_pkg::KIND_MAC;
      csrmv_pkg::OP_EMPTY: item.kind = csrmv_pkg::KIND_EMPTY;
      default: begin
        // The unused opcode is taken off the channel and dropped.
        item.kind = csrmv_pkg::KIND_WRITE;
        keep      = 1'b0;
      end
    endcase
    push = cmd.valid && !full && keep;
  end

endmodule

FILE: design/csrmv_queue.sv
// ----------------------------------------------------------------------------
// csrmv_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csrmv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  csrmv_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output csrmv_pkg::cmd_t  head_cmd
);

  localparam int DEPTH = csrmv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  csrmv_pkg::cmd_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

FILE: design/csrmv_back.sv
// ----------------------------------------------------------------------------
// csrmv_back
// Executes queued commands: vector store access, complex multiply, term
// combine and saturating accumulate, with a registered result word.
// ----------------------------------------------------------------------------
module csrmv_back #(
  parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  csrmv_pkg::cmd_t  head_cmd,
  output logic             pop,
  csrmv_out_if.source      result
);

  localparam int ADDR_W = $clog2(VEC_DEPTH);
  localparam int PW     = csrmv_pkg::PART_W;
  localparam int AW     = csrmv_pkg::ACC_W;
  localparam int RW     = csrmv_pkg::ROW_W;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  // Exact sum of the accumulator and one complex term, clamped to 64 bits.
  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] acc,
                                                   input logic signed [AW:0]   term);
    logic signed [AW+1:0] sum;
    sum = (AW+2)'(acc) + (AW+2)'(term);
    if (sum[AW+1] != sum[AW] || sum[AW] != sum[AW-1]) begin
      return sum[AW+1] ? ACC_MIN : ACC_MAX;
    end
    return sum[AW-1:0];
  endfunction

  logic                    adv;
  logic [ADDR_W-1:0]       addr;

  logic signed [PW-1:0]    vec_re [VEC_DEPTH];
  logic signed [PW-1:0]    vec_im [VEC_DEPTH];

  // Stage 1: store read data
  logic                    s1_valid;
  csrmv_pkg::kind_t        s1_kind;
  logic                    s1_in_range;
  logic                    s1_eor;
  logic signed [PW-1:0]    s1_re;
  logic signed [PW-1:0]    s1_im;
  logic signed [PW-1:0]    rd_re;
  logic signed [PW-1:0]    rd_im;
  logic signed [PW-1:0]    v_re;
  logic signed [PW-1:0]    v_im;

  // Stage 2: products
  logic                    s2_valid;
  csrmv_pkg::kind_t        s2_kind;
  logic                    s2_eor;
  logic signed [AW-1:0]    p_rr;
  logic signed [AW-1:0]    p_ii;
  logic signed [AW-1:0]    p_ri;
  logic signed [AW-1:0]    p_ir;

  // Stage 3: complex term
  logic                    s3_valid;
  csrmv_pkg::kind_t        s3_kind;
  logic                    s3_eor;
  logic signed [AW:0]      t_re;
  logic signed [AW:0]      t_im;

  // Accumulate and result
  logic signed [AW-1:0]    acc_re;
  logic signed [AW-1:0]    acc_im;
  logic signed [AW-1:0]    sum_re;
  logic signed [AW-1:0]    sum_im;
  logic [RW-1:0]           row_counter;
  logic                    emit;
  logic                    out_valid;
  logic [RW-1:0]           out_row;
  logic signed [AW-1:0]    out_re;
  logic signed [AW-1:0]    out_im;

  // The whole pipe moves together whenever the result register can take a word.
  assign adv  = !out_valid || result.ready;
  assign pop  = adv && head_valid;
  assign addr = head_cmd.addr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head_cmd.kind == csrmv_pkg::KIND_WRITE && head_cmd.in_range) begin
        vec_re[addr] <= head_cmd.re;
        vec_im[addr] <= head_cmd.im;
      end
      rd_re <= vec_re[addr];
      rd_im <= vec_im[addr];
    end
  end

  // Columns beyond the store read as zero.
  assign v_re = s1_in_range ? rd_re : '0;
  assign v_im = s1_in_range ? rd_im : '0;

  assign sum_re = sat_add(acc_re, t_re);
  assign sum_im = sat_add(acc_im, t_im);
  assign emit   = s3_valid && (s3_kind == csrmv_pkg::KIND_EMPTY ||
                               (s3_kind == csrmv_pkg::KIND_MAC && s3_eor));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind     <= head_cmd.kind;
      s1_in_range <= head_cmd.in_range;
      s1_eor      <= head_cmd.end_of_row;
      s1_re       <= head_cmd.re;
      s1_im       <= head_cmd.im;

      s2_kind <= s1_kind;
      s2_eor  <= s1_eor;
      p_rr    <= s1_re * v_re;
      p_ii    <= s1_im * v_im;
      p_ri    <= s1_re * v_im;
      p_ir    <= s1_im * v_re;

      s3_kind <= s2_kind;
      s3_eor  <= s2_eor;
      t_re    <= (AW+1)'(p_rr) - (AW+1)'(p_ii);
      t_im    <= (AW+1)'(p_ri) + (AW+1)'(p_ir);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re      <= '0;
      acc_im      <= '0;
      row_counter <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
      if (s3_valid) begin
        case (s3_kind)
          csrmv_pkg::KIND_WRITE: begin
            row_counter <= '0;
          end
          csrmv_pkg::KIND_MAC: begin
            if (s3_eor) begin
              acc_re      <= '0;
              acc_im      <= '0;
              row_counter <= row_counter + 1'b1;
            end else begin
              acc_re <= sum_re;
              acc_im <= sum_im;
            end
          end
          csrmv_pkg::KIND_EMPTY: begin
            acc_re      <= '0;
            acc_im      <= '0;
            row_counter <= row_counter + 1'b1;
          end
          default: begin
            acc_re <= acc_re;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_row <= row_counter;
      out_re  <= (s3_kind == csrmv_pkg::KIND_MAC) ? sum_re : '0;
      out_im  <= (s3_kind == csrmv_pkg::KIND_MAC) ? sum_im : '0;
    end
  end

  assign result.valid  = out_valid;
  assign result.row    = out_row;
  assign result.y_real = out_re;
  assign result.y_imag = out_im;

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && emit) |=> (acc_re == '0 && acc_im == '0))
    else $error("accumulators not cleared after a row result");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (adv && emit) |=> (row_counter == RW'($past(row_counter) + 1'b1)))
    else $error("row counter did not advance after a row result");

  a_write_rewinds: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && s3_kind == csrmv_pkg::KIND_WRITE) |=> (row_counter == '0))
    else $error("row counter not rewound by a vector write");

endmodule

FILE: design/csr_complex_sparse_matvec.sv
// ----------------------------------------------------------------------------
// csr_complex_sparse_matvec
// Streaming complex sparse matrix times vector in CSR order.
// ----------------------------------------------------------------------------
// Load the vector with write words (op 0), then stream the nonzeros (op 1)
// row after row, marking the last of each row, or close an empty row with
// op 2; each row gives one result word with its row number and a saturated
// 64-bit complex sum with twice the input fraction bits. The block takes one
// word per clock for as long as results are taken. After its closing word
// is accepted, a result passes these registered steps: the accepting edge
// writes the four-entry command queue, then come the vector store read, the
// four 32x32 multiplies, the term combine, and the saturating accumulate
// that sets the one-word-per-cycle rate. A stalled result channel halts the
// execute pipe, and the queue keeps taking words until it fills. The vector
// store has no reset; read only entries that have been written.
module csr_complex_sparse_matvec #(
  parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  csrmv_in_if.sink     cmd,
  csrmv_out_if.source  result
);

  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  csrmv_pkg::cmd_t  push_cmd;
  csrmv_pkg::cmd_t  head_cmd;

  csrmv_front #(.VEC_DEPTH(VEC_DEPTH)) u_front (
    .cmd  (cmd),
    .full (full),
    .push (push),
    .item (push_cmd)
  );

  csrmv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  csrmv_back #(.VEC_DEPTH(VEC_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .result     (result)
  );

endmodule

FILE: verif/csr_complex_sparse_matvec_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_complex_sparse_matvec_chk
// Watches both channels of the sparse matrix-vector block and checks each
// row sum against its own copy of the vector store, accumulators and row
// count, field by field and in order.
// ----------------------------------------------------------------------------
module csr_complex_sparse_matvec_chk (
  input  logic  clk,
  input  logic  rst,
  csrmv_in_if   cmd,
  csrmv_out_if  result,
  output int    mismatches,
  output int    rows_due
);

  localparam int AW    = csrmv_pkg::ACC_W;
  localparam int PW    = csrmv_pkg::PART_W;
  localparam int RW    = csrmv_pkg::ROW_W;
  localparam int IW    = csrmv_pkg::IDX_W;
  localparam int DEPTH = csrmv_pkg::VEC_DEPTH_DEF;

  typedef struct {
    logic [RW-1:0]         row;
    logic signed [AW-1:0]  y_real;
    logic signed [AW-1:0]  y_imag;
  } row_sum_t;

  logic signed [PW-1:0] vec_re [DEPTH];
  logic signed [PW-1:0] vec_im [DEPTH];
  logic signed [AW-1:0] sum_re;
  logic signed [AW-1:0] sum_im;
  logic [RW-1:0]        row_num;
  row_sum_t             row_sums_q[$];

  // The exact three-term sum fits in 66 bits; it is clamped once.
  function automatic logic signed [AW-1:0] sat_add3(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b,
                                                    input logic signed [AW-1:0] c);
    logic signed [AW+1:0] s;
    s = (AW+2)'(a) + (AW+2)'(b) + (AW+2)'(c);
    if (s[AW+1:AW-1] inside {3'b000, 3'b111}) begin
      return s[AW-1:0];
    end else if (s[AW+1]) begin
      return {1'b1, {(AW-1){1'b0}}};
    end else begin
      return {1'b0, {(AW-1){1'b1}}};
    end
  endfunction

  task automatic close_row(input logic signed [AW-1:0] yr,
                           input logic signed [AW-1:0] yi);
    row_sums_q.push_back('{row_num, yr, yi});
    sum_re  = '0;
    sum_im  = '0;
    row_num = row_num + 1'b1;
  endtask

  task automatic absorb_word(input logic [1:0]          op,
                             input logic [IW-1:0]       idx,
                             input logic signed [PW-1:0] re,
                             input logic signed [PW-1:0] im,
                             input logic                eor);
    longint a_re, a_im, v_re, v_im;
    a_re = longint'(re);
    a_im = longint'(im);
    case (op)
      csrmv_pkg::OP_WRITE: begin
        if (idx < DEPTH) begin
          vec_re[idx] = re;
          vec_im[idx] = im;
        end
        row_num = '0;
      end
      csrmv_pkg::OP_MAC: begin
        v_re = 0;
        v_im = 0;
        if (idx < DEPTH) begin
          v_re = longint'(vec_re[idx]);
          v_im = longint'(vec_im[idx]);
        end
        sum_re = sat_add3(sum_re, a_re * v_re, -(a_im * v_im));
        sum_im = sat_add3(sum_im, a_re * v_im, a_im * v_re);
        if (eor) close_row(sum_re, sum_im);
      end
      csrmv_pkg::OP_EMPTY: close_row('0, '0);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    row_sum_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      sum_re  = '0;
      sum_im  = '0;
      row_num = '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        absorb_word(cmd.op, cmd.index, cmd.re, cmd.im, cmd.end_of_row);
      end
      if (result.valid && result.ready) begin
        if (row_sums_q.size() == 0) begin
          $error("row sum word with no row closed: row %0d", result.row);
          errs++;
        end else begin
          want = row_sums_q.pop_front();
          if (result.row !== want.row) begin
            $error("row: expected %0d, got %0d", want.row, result.row);
            errs++;
          end
          if (result.y_real !== want.y_real) begin
            $error("y_real: expected %0d, got %0d", want.y_real, result.y_real);
            errs++;
          end
          if (result.y_imag !== want.y_imag) begin
            $error("y_imag: expected %0d, got %0d", want.y_imag, result.y_imag);
            errs++;
          end
        end
      end
    end
    mismatches <= mismatches + errs;
    rows_due   <= row_sums_q.size();
  end

endmodule

FILE: verif/csr_complex_sparse_matvec_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_complex_sparse_matvec_tb
// Loads vector elements and streams rows of complex nonzeros into the block:
// a directed set of extremes and saturating rows, then random rows under
// three idling mixes.
// ----------------------------------------------------------------------------
module csr_complex_sparse_matvec_tb;

  localparam int PW    = csrmv_pkg::PART_W;
  localparam int IW    = csrmv_pkg::IDX_W;
  localparam int DEPTH = csrmv_pkg::VEC_DEPTH_DEF;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [PW-1:0] PART_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PW-1:0] PART_MIN = 32'sh8000_0000;
  localparam logic signed [PW-1:0] PART_ONE = 32'sh0100_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   words_sent;
  int   mismatches;
  int   rows_due;
  bit   loaded [DEPTH];
  logic [IW-1:0] loaded_cols[$];

  csrmv_in_if  cmd ();
  csrmv_out_if result ();

  csr_complex_sparse_matvec i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .result (result)
  );

  csr_complex_sparse_matvec_chk i_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .result     (result),
    .mismatches (mismatches),
    .rows_due   (rows_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [IW-1:0] rand_idx();
    return IW'($urandom_range(DEPTH - 1));
  endfunction

  // Ready is stable from the falling edge on, so it is checked there and the
  // word counts as taken at the following rising edge.
  task automatic send_word(input logic [1:0]           op,
                           input logic [IW-1:0]        idx,
                           input logic signed [PW-1:0] re,
                           input logic signed [PW-1:0] im,
                           input logic                 eor);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd.valid      <= 1'b1;
    cmd.op         <= op;
    cmd.index      <= idx;
    cmd.re         <= re;
    cmd.im         <= im;
    cmd.end_of_row <= eor;
    @(negedge clk);
    while (!cmd.ready) @(negedge clk);
    @(posedge clk);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic load_element(input logic [IW-1:0]        idx,
                              input logic signed [PW-1:0] re,
                              input logic signed [PW-1:0] im,
                              input logic                 eor);
    send_word(csrmv_pkg::OP_WRITE, idx, re, im, eor);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
  endtask

  function automatic logic signed [PW-1:0] rand_part();
    case ($urandom_range(7))
      0: return PART_MIN;
      1: return PART_MAX;
      2, 3: return 32'($urandom_range(32'h0200_0000)) - PART_ONE;
      default: return $urandom;
    endcase
  endfunction

  // Only columns already loaded are ever read back.
  function automatic logic [IW-1:0] loaded_col();
    return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
  endfunction

  task automatic run_directed();
    load_element(10'h000, PART_MAX, PART_MIN, 1'b1);
    load_element(10'h3FF, PART_MIN, PART_MIN, 1'b0);
    load_element(10'h155, PART_ONE, -PART_ONE, 1'b0);
    load_element(10'h2AA, '0, '0, 1'b0);
    send_word(csrmv_pkg::OP_MAC, 10'h155, PART_ONE, -PART_ONE, 1'b1);
    send_word(csrmv_pkg::OP_EMPTY, 10'h3FF, PART_MAX, PART_MIN, 1'b1);
    // Two terms near the top of the range clamp high; a large negative term
    // then works on the clamped sum.
    send_word(csrmv_pkg::OP_MAC, 10'h3FF, PART_MIN, PART_MAX, 1'b0);
    send_word(csrmv_pkg::OP_MAC, 10'h3FF, PART_MIN, PART_MAX, 1'b0);
    send_word(csrmv_pkg::OP_MAC, 10'h3FF, PART_MAX, PART_MIN, 1'b1);
    send_word(csrmv_pkg::OP_MAC, 10'h3FF, PART_MAX, PART_MIN, 1'b0);
    send_word(csrmv_pkg::OP_MAC, 10'h3FF, PART_MAX, PART_MIN, 1'b0);
    send_word(csrmv_pkg::OP_MAC, 10'h000, PART_MIN, PART_MIN, 1'b1);
    // A partial sum thrown away by an empty-row close.
    send_word(csrmv_pkg::OP_MAC, 10'h000, PART_MAX, PART_MAX, 1'b0);
    send_word(csrmv_pkg::OP_EMPTY, '0, '0, '0, 1'b0);
    // A vector write in mid-row keeps the partial sum but restarts the count.
    send_word(csrmv_pkg::OP_MAC, 10'h155, PART_MIN, PART_MAX, 1'b0);
    load_element(10'h200, PART_ONE, PART_ONE, 1'b0);
    send_word(csrmv_pkg::OP_MAC, 10'h200, PART_ONE, PART_ONE, 1'b1);
    send_word(OP_UNUSED, 10'h3FF, PART_MIN, PART_MAX, 1'b1);
    send_word(csrmv_pkg::OP_MAC, 10'h2AA, PART_MAX, PART_MIN, 1'b1);
  endtask

  task automatic run_random(input int words);
    int stop_at, pick, n;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_element(rand_idx(), rand_part(), rand_part(), rand_bit());
      end else if (pick < 12) begin
        send_word(OP_UNUSED, rand_idx(), $urandom, $urandom, rand_bit());
      end else if (pick < 20) begin
        send_word(csrmv_pkg::OP_EMPTY, rand_idx(), rand_part(), rand_part(), rand_bit());
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 1; k <= n; k++) begin
          if ($urandom_range(24) == 0) begin
            load_element(rand_idx(), rand_part(), rand_part(), rand_bit());
          end else if ($urandom_range(40) == 0) begin
            send_word(csrmv_pkg::OP_EMPTY, rand_idx(), $urandom, $urandom, rand_bit());
          end
          send_word(csrmv_pkg::OP_MAC, loaded_col(), rand_part(), rand_part(), k == n);
        end
      end
    end
  endtask

  initial begin
    cmd.valid      = 1'b0;
    cmd.op         = csrmv_pkg::OP_WRITE;
    cmd.index      = '0;
    cmd.re         = '0;
    cmd.im         = '0;
    cmd.end_of_row = 1'b0;
    send_idle_pct  = 13;
    recv_idle_pct  = 62;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(142);
    send_idle_pct = 62;
    recv_idle_pct = 13;
    run_random(142);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(141);
    cmd.valid <= 1'b0;

    while (rows_due != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
